/* src/smru_pkg.sv */
package smru_pkg;

    // Record-walk phases, one-hot
    typedef enum logic [4:0] {
        PH_IDLE    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_CONTROL = 5'b01000,
        PH_DATA    = 5'b10000
    } phase_t;

    // Status codes on the response
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_TERM    = 3'd2;
    localparam logic [2:0] ST_LIMIT   = 3'd3;
    localparam logic [2:0] ST_ILLEGAL = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SELF_DEFINING = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] CFG_GROUP_COUNT   = 2'd2;

    localparam logic [19:0] LIM_MAX = 20'hFFFFF;

    // Reciprocal constants: x / 1000 = (x * M1K) >> 38, x / 1000000 = (x * M1M) >> 50,
    // exact for any 32-bit unsigned x
    localparam logic [63:0] M1K = 64'd274877907;
    localparam logic [63:0] M1M = 64'd1125899907;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

/* src/scatter_matrix_record_unpacker.sv */
// Each request passes through the input register, then the result register, before
// its response is valid.
// Throughput: one request per cycle without stall; every request yields exactly one response.
// Under response stall the input register still takes one more request, then req_stall rises.
// Reset (rst_n low, asynchronous): walk goes idle, counters clear, config returns to
// self_defining = 0, max_length = 0, group_count = 1; no response is pending.
module scatter_matrix_record_unpacker
    import smru_pkg::*;
#(
    parameter int MAX_GROUPS = 999
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [31:0] word,
    input  logic        start_req,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        write_valid,
    output logic [19:0] address,
    output logic [31:0] value,
    output logic [2:0]  status
);

    localparam logic [9:0] GROUPS_CAP = 10'(MAX_GROUPS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        self_defining_reg;
    logic [19:0] max_length_reg;
    logic [9:0]  group_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_defining_reg <= 1'b0;
            max_length_reg    <= '0;
            group_count_reg   <= 10'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SELF_DEFINING: self_defining_reg <= cfg_data[0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_data;
                CFG_GROUP_COUNT:   group_count_reg   <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register -> decode/state -> result register
    // ---------------------------------------------------------------
    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;     // already byte-swapped
    logic        s1_start_reg;
    logic        rsp_valid_reg;
    logic        req_take;
    logic        advance;

    // The request in the input register moves on whenever the result slot is free
    // or being drained this cycle.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_word_reg  <= swap32(word);
            s1_start_reg <= start_req;
        end
    end

    // ---------------------------------------------------------------
    // Record walk state
    // ---------------------------------------------------------------
    phase_t      phase_reg, phase_next;
    logic [19:0] words_used_reg, words_used_next;
    logic [19:0] length_limit_reg, length_limit_next;
    logic [9:0]  source_now_reg, source_now_next;
    logic [9:0]  source_first_reg, source_first_next;
    logic [9:0]  sink_now_reg, sink_now_next;

    // Effective group count, capped by the build limit
    logic [9:0] groups;
    assign groups = (group_count_reg > GROUPS_CAP) ? GROUPS_CAP : group_count_reg;

    // Control word decode: first.last.sink as decimal fields, via reciprocal multiplies
    logic [63:0] q1k_prod;
    logic [63:0] q1m_prod;
    logic [22:0] q1k;            // word / 1000
    logic [12:0] first_src;      // word / 1000000
    logic [31:0] sink_rem;
    logic [22:0] last_rem;
    logic [9:0]  ctl_sink;
    logic [9:0]  ctl_last;
    logic        ctl_bad;

    assign q1k_prod  = {32'd0, s1_word_reg} * M1K;
    assign q1m_prod  = {32'd0, s1_word_reg} * M1M;
    assign q1k       = q1k_prod[60:38];
    assign first_src = q1m_prod[62:50];
    assign sink_rem  = s1_word_reg - 32'({9'd0, q1k} * 32'd1000);
    assign last_rem  = q1k - 23'({10'd0, first_src} * 23'd1000);
    assign ctl_sink  = sink_rem[9:0];
    assign ctl_last  = last_rem[9:0];
    assign ctl_bad   = (ctl_sink == '0) || (ctl_last == '0) || (first_src == '0) ||
                       (ctl_sink > groups) || (ctl_last > groups) ||
                       (first_src > 13'(groups));

    // Matrix address of the current data word (row = source - 1, column = sink - 1)
    logic [19:0] row_prod;
    logic [20:0] addr_sum;
    assign row_prod = 20'(source_now_reg - 10'd1) * 20'(groups);
    assign addr_sum = 21'(row_prod) + 21'(sink_now_reg) - 21'd1;

    // Saturating word count for control and data words
    logic [19:0] words_inc;
    assign words_inc = (words_used_reg == LIM_MAX) ? LIM_MAX : words_used_reg + 20'd1;

    // Limit taken from the stream: negative reads as zero, large values saturate
    logic [19:0] stream_limit;
    assign stream_limit = s1_word_reg[31] ? 20'd0 :
                          (s1_word_reg > 32'(LIM_MAX)) ? LIM_MAX : s1_word_reg[19:0];

    logic        wv_next;
    logic [19:0] addr_next;
    logic [31:0] val_next;
    logic [2:0]  st_next;

    always_comb
    begin
        phase_next        = phase_reg;
        words_used_next   = words_used_reg;
        length_limit_next = length_limit_reg;
        source_now_next   = source_now_reg;
        source_first_next = source_first_reg;
        sink_now_next     = sink_now_reg;
        wv_next           = 1'b0;
        addr_next         = '0;
        val_next          = '0;
        st_next           = ST_IDLE;

        priority if (s1_start_reg)
        begin
            // a start always restarts, even mid-record
            phase_next = PH_HEADER;
            st_next    = ST_BUSY;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (self_defining_reg)
                    begin
                        phase_next = PH_LENGTH;
                        st_next    = ST_BUSY;
                    end
                    else
                    begin
                        length_limit_next = max_length_reg;
                        words_used_next   = '0;
                        phase_next        = (max_length_reg == '0) ? PH_IDLE : PH_CONTROL;
                        st_next           = (max_length_reg == '0) ? ST_LIMIT : ST_BUSY;
                    end
                end
                PH_LENGTH:
                begin
                    length_limit_next = stream_limit;
                    words_used_next   = '0;
                    phase_next        = (stream_limit == '0) ? PH_IDLE : PH_CONTROL;
                    st_next           = (stream_limit == '0) ? ST_LIMIT : ST_BUSY;
                end
                PH_CONTROL:
                begin
                    words_used_next = words_inc;
                    if ((s1_word_reg == '0) || s1_word_reg[31])
                    begin
                        phase_next = PH_IDLE;
                        st_next    = ST_TERM;
                    end
                    else if (ctl_bad)
                    begin
                        phase_next = PH_IDLE;
                        st_next    = ST_ILLEGAL;
                    end
                    else if (first_src > 13'(ctl_last))
                    begin
                        // empty source range: no data follows, limit checked now
                        phase_next = (words_inc >= length_limit_reg) ? PH_IDLE : PH_CONTROL;
                        st_next    = (words_inc >= length_limit_reg) ? ST_LIMIT : ST_BUSY;
                    end
                    else
                    begin
                        source_now_next   = ctl_last;
                        source_first_next = first_src[9:0];
                        sink_now_next     = ctl_sink;
                        phase_next        = PH_DATA;
                        st_next           = ST_BUSY;
                    end
                end
                PH_DATA:
                begin
                    words_used_next = words_inc;
                    wv_next         = 1'b1;
                    val_next        = s1_word_reg;
                    addr_next       = addr_sum[19:0];
                    if (source_now_reg <= source_first_reg)
                    begin
                        // group done; the limit is tested here, or in the control phase on an empty source range
                        phase_next = (words_inc >= length_limit_reg) ? PH_IDLE : PH_CONTROL;
                        st_next    = (words_inc >= length_limit_reg) ? ST_LIMIT : ST_BUSY;
                    end
                    else
                    begin
                        source_now_next = source_now_reg - 10'd1;
                        st_next         = ST_BUSY;
                    end
                end
                PH_IDLE:
                begin
                    // trailing padding, ignored until the next start
                    phase_next = PH_IDLE;
                    st_next    = ST_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    st_next    = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            words_used_reg   <= '0;
            length_limit_reg <= '0;
            source_now_reg   <= '0;
            source_first_reg <= '0;
            sink_now_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            words_used_reg   <= words_used_next;
            length_limit_reg <= length_limit_next;
            source_now_reg   <= source_now_next;
            source_first_reg <= source_first_next;
            sink_now_reg     <= sink_now_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic        write_valid_reg;
    logic [19:0] address_reg;
    logic [31:0] value_reg;
    logic [2:0]  status_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            write_valid_reg <= wv_next;
            address_reg     <= addr_next;
            value_reg       <= val_next;
            status_reg      <= st_next;
        end
    end

    assign write_valid = write_valid_reg;
    assign address     = address_reg;
    assign value       = value_reg;
    assign status      = status_reg;

endmodule

/* src/smru_checker.sv */
module smru_checker
    import smru_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        write_valid,
    input logic [19:0] address,
    input logic [31:0] value,
    input logic [2:0]  status
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(write_valid) &&
        $stable(address) && $stable(value) && $stable(status))
        else $error("stalled response changed");

    // a matrix write only happens inside a live record or on its limit end
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && write_valid |-> (status == ST_BUSY) || (status == ST_LIMIT))
        else $error("write with a non-busy status");

    // no write means zero address and value
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !write_valid |-> (address == '0) && (value == '0))
        else $error("non-write response carries data");

    // nothing is pending right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !rsp_valid)
        else $error("response valid out of reset");

endmodule

bind scatter_matrix_record_unpacker smru_checker u_smru_checker (.*);
